>>> rtl/tcse_pkg.sv
// ----------------------------------------------------------------------------
// tcse_pkg
// Types, codes and parse-step functions of the ClientHello server-name
// extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package tcse_pkg;

    localparam logic [7:0]  HS_CONTENT_TYPE = 8'd22;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0]  NAME_TYPE_HOST  = 8'h00;
    localparam logic [16:0] RANDOM_BYTES    = 17'd32;
    localparam logic [16:0] POS_MAX         = 17'h1FFFF;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NEED  = 2'd1,
        ST_NOTCH = 2'd2,
        ST_MAL   = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        PH_REC   = 5'd0,
        PH_HS    = 5'd1,
        PH_VER   = 5'd2,
        PH_RAND  = 5'd3,
        PH_SIDL  = 5'd4,
        PH_SID   = 5'd5,
        PH_CSL   = 5'd6,
        PH_CS    = 5'd7,
        PH_COMPL = 5'd8,
        PH_COMP  = 5'd9,
        PH_EXTL  = 5'd10,
        PH_EXTT  = 5'd11,
        PH_ELSN  = 5'd12,
        PH_ELOT  = 5'd13,
        PH_EXTSK = 5'd14,
        PH_LISTL = 5'd15,
        PH_ENTH  = 5'd16,
        PH_ENTSK = 5'd17,
        PH_NAME  = 5'd18,
        PH_DONE  = 5'd19
    } t_phase;

    typedef struct packed {
        logic [16:0] pos;
        t_phase      phase;
        logic [16:0] rec_end;
        logic [16:0] hs_end;
        logic [16:0] exts_end;
        logic [16:0] ext_end;
        logic [16:0] nl_end;
        logic [23:0] acc;
        logic [16:0] skip;
        t_status     lstat;
        logic        vlat;
        logic        nfound;
        logic [7:0]  ncount;
        logic [15:0] srec;
        logic [15:0] sver;
    } t_state;

    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  name_byte;
        t_status     status;
        logic        has_name;
        logic [7:0]  name_length;
        logic [15:0] rec_len;
        logic [15:0] hello_version;
        logic        last_of_run;
    } t_result;

    function automatic t_state f_reset();
        t_state s;
        s       = '0;
        s.phase = PH_REC;
        s.lstat = ST_OK;
        return s;
    endfunction

    function automatic logic f_over(logic [16:0] off, logic [16:0] n, logic [16:0] lim);
        return ({1'b0, off} + {1'b0, n}) > {1'b0, lim};
    endfunction

    function automatic t_state f_latch(t_state s_in, t_status st);
        t_state s;
        s       = s_in;
        s.lstat = st;
        s.vlat  = 1'b1;
        s.phase = PH_DONE;
        return s;
    endfunction

    function automatic t_state f_field(t_state s_in, t_phase ph, logic [16:0] n,
                                       logic [16:0] need, logic [16:0] lim,
                                       logic [16:0] off);
        t_state s;
        s = s_in;
        if (f_over(off, need, lim)) begin
            s = f_latch(s, ST_MAL);
        end else begin
            s.phase = ph;
            s.skip  = n;
            s.acc   = '0;
        end
        return s;
    endfunction

    function automatic t_state f_ext_loop(t_state s_in, logic [16:0] off);
        t_state s;
        s = s_in;
        if (off >= s.exts_end) begin
            s = f_latch(s, ST_OK);
        end else begin
            s = f_field(s, PH_EXTT, 17'd2, 17'd4, s.exts_end, off);
        end
        return s;
    endfunction

    function automatic t_state f_ent_loop(t_state s_in, logic [16:0] off);
        t_state s;
        s = s_in;
        if (off >= s.nl_end) begin
            s = f_latch(s, ST_OK);
        end else begin
            s = f_field(s, PH_ENTH, 17'd3, 17'd3, s.nl_end, off);
        end
        return s;
    endfunction

    function automatic t_state f_after_skip(t_state s_in, t_phase ph, logic [16:0] off);
        t_state s;
        s = s_in;
        case (ph)
            PH_RAND: s = f_field(s, PH_SIDL, 17'd1, 17'd1, s.hs_end, off);
            PH_SID:  s = f_field(s, PH_CSL, 17'd2, 17'd2, s.hs_end, off);
            PH_CS:   s = f_field(s, PH_COMPL, 17'd1, 17'd1, s.hs_end, off);
            PH_COMP: begin
                if (off == s.hs_end) begin
                    s = f_latch(s, ST_OK);
                end else begin
                    s = f_field(s, PH_EXTL, 17'd2, 17'd2, s.hs_end, off);
                end
            end
            PH_EXTSK: s = f_ext_loop(s, off);
            PH_ENTSK: s = f_ent_loop(s, off);
            default:  s.phase = PH_DONE;
        endcase
        return s;
    endfunction

    function automatic t_state f_skip_to(t_state s_in, t_phase ph, logic [16:0] n,
                                         logic [16:0] lim, logic [16:0] off);
        t_state s;
        s = s_in;
        if (f_over(off, n, lim)) begin
            s = f_latch(s, ST_MAL);
        end else begin
            s.phase = ph;
            s.skip  = n;
            if (n == '0) begin
                s = f_after_skip(s, ph, off);
            end
        end
        return s;
    endfunction

    function automatic t_state f_field_done(t_state s_in, logic [16:0] off,
                                            logic [16:0] name_lim);
        t_state      s;
        logic [16:0] v16;
        logic [24:0] hs_sum;
        s      = s_in;
        v16    = {1'b0, s.acc[15:0]};
        hs_sum = {8'd0, off} + {1'b0, s.acc};
        case (s.phase)
            PH_HS: begin
                if (hs_sum > {8'd0, s.rec_end}) begin
                    s = f_latch(s, ST_MAL);
                end else begin
                    s.hs_end = hs_sum[16:0];
                    s = f_field(s, PH_VER, 17'd2, 17'd34, s.hs_end, off);
                end
            end
            PH_VER: begin
                s.sver  = s.acc[15:0];
                s.phase = PH_RAND;
                s.skip  = RANDOM_BYTES;
            end
            PH_SIDL: s = f_skip_to(s, PH_SID, {9'd0, s.acc[7:0]}, s.hs_end, off);
            PH_CSL: begin
                if (s.acc[0]) begin
                    s = f_latch(s, ST_MAL);
                end else begin
                    s = f_skip_to(s, PH_CS, v16, s.hs_end, off);
                end
            end
            PH_COMPL: s = f_skip_to(s, PH_COMP, {9'd0, s.acc[7:0]}, s.hs_end, off);
            PH_EXTL: begin
                if (f_over(off, v16, s.hs_end)) begin
                    s = f_latch(s, ST_MAL);
                end else begin
                    s.exts_end = off + v16;
                    s = f_ext_loop(s, off);
                end
            end
            PH_EXTT: begin
                s.phase = (s.acc[15:0] == EXT_SERVER_NAME) ? PH_ELSN : PH_ELOT;
                s.skip  = 17'd2;
                s.acc   = '0;
            end
            PH_ELOT: s = f_skip_to(s, PH_EXTSK, v16, s.exts_end, off);
            PH_ELSN: begin
                if (f_over(off, v16, s.exts_end)) begin
                    s = f_latch(s, ST_MAL);
                end else begin
                    s.ext_end = off + v16;
                    s = f_field(s, PH_LISTL, 17'd2, 17'd2, s.ext_end, off);
                end
            end
            PH_LISTL: begin
                if (f_over(off, v16, s.ext_end)) begin
                    s = f_latch(s, ST_MAL);
                end else begin
                    s.nl_end = off + v16;
                    s = f_ent_loop(s, off);
                end
            end
            PH_ENTH: begin
                if (f_over(off, v16, s.nl_end)) begin
                    s = f_latch(s, ST_MAL);
                end else if (s.acc[23:16] == NAME_TYPE_HOST) begin
                    if (v16 == '0 || v16 >= name_lim) begin
                        s = f_latch(s, ST_MAL);
                    end else begin
                        s.lstat  = ST_OK;
                        s.vlat   = 1'b1;
                        s.nfound = 1'b1;
                        s.ncount = v16[7:0];
                        s.phase  = PH_NAME;
                        s.skip   = v16;
                    end
                end else begin
                    s = f_skip_to(s, PH_ENTSK, v16, s.nl_end, off);
                end
            end
            default: s.phase = PH_DONE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tcse_parser.sv
// ----------------------------------------------------------------------------
// tcse_parser
// Parse state register and the one-byte step of the ClientHello walk.
// ----------------------------------------------------------------------------
`default_nettype none

module tcse_parser #(
    parameter int NAME_LIMIT = 256
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_go,
    input  wire  [7:0]             i_byte,
    input  wire                    i_last,
    output tcse_pkg::t_result      o_res0,
    output tcse_pkg::t_result      o_res1,
    output logic [1:0]             o_nres
);
    import tcse_pkg::*;

    localparam logic [16:0] NameLim = 17'(NAME_LIMIT);

    t_state      r_st;
    t_state      n_st;
    t_state      s;
    logic [16:0] off;
    logic [16:0] nxt;
    t_phase      ph;
    logic        emit_name;
    t_result     name_res;
    t_result     verdict;
    t_status     vst;
    logic        named;

    always_comb begin
        s         = r_st;
        off       = r_st.pos;
        nxt       = (off != POS_MAX) ? off + 17'd1 : off;
        ph        = r_st.phase;
        emit_name = 1'b0;
        case (ph)
            PH_REC: begin
                if (off == '0 && i_byte != HS_CONTENT_TYPE) begin
                    s = f_latch(s, ST_NOTCH);
                end else begin
                    s.acc = {s.acc[15:0], i_byte};
                    if (off >= 17'd4) begin
                        if (s.acc[15:0] == '0) begin
                            s = f_latch(s, ST_MAL);
                        end else begin
                            s.srec    = s.acc[15:0];
                            s.rec_end = 17'd5 + {1'b0, s.acc[15:0]};
                            s = f_field(s, PH_HS, 17'd4, 17'd4, s.rec_end, nxt);
                        end
                    end
                end
            end
            PH_RAND, PH_SID, PH_CS, PH_COMP, PH_EXTSK, PH_ENTSK, PH_NAME: begin
                emit_name = (ph == PH_NAME);
                if (s.skip != '0) begin
                    s.skip = s.skip - 17'd1;
                end
                if (s.skip == '0) begin
                    s = f_after_skip(s, ph, nxt);
                end
            end
            PH_DONE: begin
            end
            default: begin
                if (ph == PH_HS && s.skip == 17'd4 && i_byte != HS_CLIENT_HELLO) begin
                    s = f_latch(s, ST_NOTCH);
                end else begin
                    s.acc = {s.acc[15:0], i_byte};
                    if (s.skip != '0) begin
                        s.skip = s.skip - 17'd1;
                    end
                    if (s.skip == '0) begin
                        s = f_field_done(s, nxt, NameLim);
                    end
                end
            end
        endcase
        s.pos = nxt;

        name_res             = '0;
        name_res.name_byte   = i_byte;
        name_res.last_of_run = !i_last;

        vst                  = s.vlat ? s.lstat : ST_MAL;
        named                = s.nfound && (vst == ST_OK);
        verdict              = '0;
        verdict.is_verdict   = 1'b1;
        verdict.last_of_run  = 1'b1;
        if (nxt < 17'd5) begin
            verdict.status = ST_NEED;
        end else if (nxt < s.rec_end) begin
            verdict.status  = ST_NEED;
            verdict.rec_len = s.srec;
        end else begin
            verdict.status        = vst;
            verdict.has_name      = named;
            verdict.name_length   = named ? s.ncount : 8'd0;
            verdict.rec_len       = s.srec;
            verdict.hello_version = s.sver;
        end

        n_st = i_last ? f_reset() : s;

        if (emit_name) begin
            o_res0 = name_res;
            o_res1 = verdict;
        end else begin
            o_res0 = verdict;
            o_res1 = verdict;
        end
        o_nres = {1'b0, emit_name} + {1'b0, i_last};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= f_reset();
        end else if (i_go) begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tcse_out_q.sv
// ----------------------------------------------------------------------------
// tcse_out_q
// Four-entry result queue; takes up to two results a cycle while it has room, gives one unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tcse_out_q (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  tcse_pkg::t_result      i_res0,
    input  tcse_pkg::t_result      i_res1,
    input  wire  [1:0]             i_push,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire                    i_stall,
    output tcse_pkg::t_result      o_res
);
    import tcse_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_room  = (r_cnt <= 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + i_push;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_push} - {2'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue count above depth");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push != 2'd0) |-> o_room) else $error("push without room");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_cnt == 3'd0)) else $error("queue not empty after reset");

endmodule

`default_nettype wire

>>> rtl/tls_clienthello_sni_extractor_unit.sv
// ----------------------------------------------------------------------------
// tls_clienthello_sni_extractor_unit
// Byte-serial TLS ClientHello parser that reports the first host name.
// ----------------------------------------------------------------------------
// Takes one buffer byte per cycle while the result queue has room. Each byte
// lands in an input register, offset arithmetic updates the parse state, and
// its results (a name byte, a verdict, or both when a name byte ends the
// buffer) go into a four-entry result queue, so a byte that yields two results
// takes two queue entries. Its first result reaches the output from the queue
// memory, after the input register.
`default_nettype none

module tls_clienthello_sni_extractor_unit #(
    parameter int NAME_LIMIT = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_end_of_buffer,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_is_verdict,
    output logic [7:0]  o_name_byte,
    output logic [1:0]  o_status,
    output logic        o_has_name,
    output logic [7:0]  o_name_length,
    output logic [15:0] o_record_length,
    output logic [15:0] o_hello_version,
    output logic        o_last_of_run
);
    import tcse_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       room;
    logic       go;
    t_result    res0;
    t_result    res1;
    logic [1:0] nres;
    logic [1:0] push;
    t_result    q_out;

    assign go      = r_in_vld && room;
    assign o_stall = r_in_vld && !room;
    assign push    = go ? nres : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_vld <= 1'b1;
        end else if (go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_end_of_buffer;
        end
    end

    tcse_parser #(
        .NAME_LIMIT (NAME_LIMIT)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_nres  (nres)
    );

    tcse_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (q_out)
    );

    assign o_is_verdict    = q_out.is_verdict;
    assign o_name_byte     = q_out.name_byte;
    assign o_status        = q_out.status;
    assign o_has_name      = q_out.has_name;
    assign o_name_length   = q_out.name_length;
    assign o_record_length = q_out.rec_len;
    assign o_hello_version = q_out.hello_version;
    assign o_last_of_run   = q_out.last_of_run;

endmodule

`default_nettype wire

>>> bench/tls_clienthello_sni_extractor_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ClientHello server-name extractor bench
// Feeds the extractor generated buffers, mostly well-formed ClientHello records
// with random content plus truncated, corrupted and noise buffers. A local
// parse model predicts every name byte and verdict; each output transaction
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_clienthello_sni_extractor_unit_tb;
    import tcse_pkg::*;

    localparam int HOST_LIMIT = 256;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       known;
        t_result    res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_buffer;
    logic        o_valid;
    logic        i_stall;
    logic        o_is_verdict;
    logic [7:0]  o_name_byte;
    logic [1:0]  o_status;
    logic        o_has_name;
    logic [7:0]  o_name_length;
    logic [15:0] o_record_length;
    logic [15:0] o_hello_version;
    logic        o_last_of_run;

    t_result     pending_results[$];
    int          mismatches;
    int          cycles;
    bit          feeding_done;

    // parse model state
    int unsigned m_pos, m_rec_end, m_hs_end, m_exts_end, m_ext_end, m_list_end;
    int unsigned m_acc, m_skip, m_ncount, m_srec, m_sver;
    t_phase      m_phase;
    t_status     m_lstat;
    bit          m_vlat, m_nfound;

    tls_clienthello_sni_extractor_unit #(.NAME_LIMIT(HOST_LIMIT)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void parse_clear();
        m_pos = 0; m_phase = PH_REC; m_rec_end = 0; m_hs_end = 0;
        m_exts_end = 0; m_ext_end = 0; m_list_end = 0; m_acc = 0; m_skip = 0;
        m_lstat = ST_OK; m_vlat = 0; m_nfound = 0; m_ncount = 0;
        m_srec = 0; m_sver = 0;
    endfunction

    function automatic void settle(t_status st);
        m_lstat = st;
        m_vlat = 1;
        m_phase = PH_DONE;
    endfunction

    function automatic void open_field(t_phase ph, int unsigned n, int unsigned need,
                                       int unsigned lim, int unsigned off);
        if (off + need > lim) settle(ST_MAL);
        else begin
            m_phase = ph;
            m_skip = n;
            m_acc = 0;
        end
    endfunction

    function automatic void next_ext(int unsigned off);
        if (off >= m_exts_end) settle(ST_OK);
        else open_field(PH_EXTT, 2, 4, m_exts_end, off);
    endfunction

    function automatic void next_entry(int unsigned off);
        if (off >= m_list_end) settle(ST_OK);
        else open_field(PH_ENTH, 3, 3, m_list_end, off);
    endfunction

    function automatic void skip_over(t_phase ph, int unsigned off);
        case (ph)
            PH_RAND: open_field(PH_SIDL, 1, 1, m_hs_end, off);
            PH_SID: open_field(PH_CSL, 2, 2, m_hs_end, off);
            PH_CS: open_field(PH_COMPL, 1, 1, m_hs_end, off);
            PH_COMP: begin
                if (off == m_hs_end) settle(ST_OK);
                else open_field(PH_EXTL, 2, 2, m_hs_end, off);
            end
            PH_EXTSK: next_ext(off);
            PH_ENTSK: next_entry(off);
            default: m_phase = PH_DONE;
        endcase
    endfunction

    function automatic void open_skip(t_phase ph, int unsigned n, int unsigned lim,
                                      int unsigned off);
        if (off + n > lim) settle(ST_MAL);
        else begin
            m_phase = ph;
            m_skip = n;
            if (n == 0) skip_over(ph, off);
        end
    endfunction

    function automatic void close_field(int unsigned off);
        int unsigned v16;
        v16 = m_acc & 16'hFFFF;
        case (m_phase)
            PH_HS: begin
                if (off + m_acc > m_rec_end) settle(ST_MAL);
                else begin
                    m_hs_end = off + m_acc;
                    open_field(PH_VER, 2, 34, m_hs_end, off);
                end
            end
            PH_VER: begin
                m_sver = v16;
                m_phase = PH_RAND;
                m_skip = 32;
            end
            PH_SIDL: open_skip(PH_SID, m_acc & 8'hFF, m_hs_end, off);
            PH_CSL: begin
                if (v16 & 1) settle(ST_MAL);
                else open_skip(PH_CS, v16, m_hs_end, off);
            end
            PH_COMPL: open_skip(PH_COMP, m_acc & 8'hFF, m_hs_end, off);
            PH_EXTL: begin
                if (off + v16 > m_hs_end) settle(ST_MAL);
                else begin
                    m_exts_end = off + v16;
                    next_ext(off);
                end
            end
            PH_EXTT: begin
                m_phase = (v16 == EXT_SERVER_NAME) ? PH_ELSN : PH_ELOT;
                m_skip = 2;
                m_acc = 0;
            end
            PH_ELOT: open_skip(PH_EXTSK, v16, m_exts_end, off);
            PH_ELSN: begin
                if (off + v16 > m_exts_end) settle(ST_MAL);
                else begin
                    m_ext_end = off + v16;
                    open_field(PH_LISTL, 2, 2, m_ext_end, off);
                end
            end
            PH_LISTL: begin
                if (off + v16 > m_ext_end) settle(ST_MAL);
                else begin
                    m_list_end = off + v16;
                    next_entry(off);
                end
            end
            PH_ENTH: begin
                if (off + v16 > m_list_end) settle(ST_MAL);
                else if (((m_acc >> 16) & 8'hFF) == NAME_TYPE_HOST) begin
                    if (v16 == 0 || v16 >= HOST_LIMIT) settle(ST_MAL);
                    else begin
                        m_lstat = ST_OK;
                        m_vlat = 1;
                        m_nfound = 1;
                        m_ncount = v16 & 8'hFF;
                        m_phase = PH_NAME;
                        m_skip = v16;
                    end
                end else open_skip(PH_ENTSK, v16, m_list_end, off);
            end
            default: m_phase = PH_DONE;
        endcase
    endfunction

    // advance the parse model by one byte and queue its results
    function automatic void predict_byte(logic [7:0] b, logic last);
        int unsigned off, nxt;
        t_phase      ph;
        t_result     r;
        t_status     st;
        int          first;
        off = m_pos;
        nxt = (off < POS_MAX) ? off + 1 : POS_MAX;
        ph = m_phase;
        first = pending_results.size();
        if (ph == PH_REC) begin
            if (off == 0 && b != HS_CONTENT_TYPE) settle(ST_NOTCH);
            else begin
                m_acc = ((m_acc << 8) | b) & 24'hFFFFFF;
                if (off >= 4) begin
                    if ((m_acc & 16'hFFFF) == 0) settle(ST_MAL);
                    else begin
                        m_srec = m_acc & 16'hFFFF;
                        m_rec_end = 5 + m_srec;
                        open_field(PH_HS, 4, 4, m_rec_end, nxt);
                    end
                end
            end
        end else if (ph inside {PH_RAND, PH_SID, PH_CS, PH_COMP, PH_EXTSK, PH_ENTSK,
                                PH_NAME}) begin
            if (ph == PH_NAME) begin
                r = '0;
                r.name_byte = b;
                pending_results.push_back(r);
            end
            if (m_skip > 0) m_skip--;
            if (m_skip == 0) skip_over(ph, nxt);
        end else if (ph != PH_DONE) begin
            if (ph == PH_HS && m_skip == 4 && b != HS_CLIENT_HELLO) settle(ST_NOTCH);
            else begin
                m_acc = ((m_acc << 8) | b) & 24'hFFFFFF;
                if (m_skip > 0) m_skip--;
                if (m_skip == 0) close_field(nxt);
            end
        end
        m_pos = nxt;
        if (last) begin
            r = '0;
            r.is_verdict = 1'b1;
            if (nxt < 5) r.status = ST_NEED;
            else if (nxt < m_rec_end) begin
                r.status = ST_NEED;
                r.rec_len = 16'(m_srec);
            end else begin
                st = m_vlat ? m_lstat : ST_MAL;
                r.status = st;
                r.has_name = m_nfound && st == ST_OK;
                r.name_length = r.has_name ? m_ncount[7:0] : 8'd0;
                r.rec_len = 16'(m_srec);
                r.hello_version = 16'(m_sver);
            end
            pending_results.push_back(r);
            parse_clear();
        end
        if (pending_results.size() > first)
            pending_results[pending_results.size() - 1].last_of_run = 1'b1;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_end_of_buffer <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_byte(b, last);
    endtask

    task automatic send_buffer(byte unsigned buf_bytes[$]);
        foreach (buf_bytes[k]) send_byte(buf_bytes[k], k == buf_bytes.size() - 1);
    endtask

    // drop valid and hold until every expected result has come
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // build a ClientHello record with random content
    function automatic void build_hello(output byte unsigned pkt[$], input int host_len,
                                        input bit decoy_ext, input bit decoy_entry);
        byte unsigned body[$], exts[$], list[$];
        int n;
        pkt = {};
        n = $urandom_range(0, 4);
        if (decoy_entry) begin
            list.push_back(8'($urandom_range(1, 255)));
            list.push_back(8'h00); list.push_back(8'(n));
            repeat (n) list.push_back(8'($urandom));
        end
        if (host_len > 0) begin
            list.push_back(NAME_TYPE_HOST);
            list.push_back(8'(host_len >> 8)); list.push_back(8'(host_len & 255));
            repeat (host_len) list.push_back(8'($urandom));
        end
        if (decoy_ext) begin
            exts.push_back(8'($urandom_range(0, 255)));
            exts.push_back(8'($urandom_range(1, 255)));
            exts.push_back(8'h00); exts.push_back(8'(n));
            repeat (n) exts.push_back(8'($urandom));
        end
        if (list.size() > 0 || $urandom_range(0, 1)) begin
            exts.push_back(8'h00); exts.push_back(8'h00);
            exts.push_back(8'((list.size() + 2) >> 8));
            exts.push_back(8'((list.size() + 2) & 255));
            exts.push_back(8'(list.size() >> 8)); exts.push_back(8'(list.size() & 255));
            foreach (list[k]) exts.push_back(list[k]);
        end
        body.push_back(8'($urandom)); body.push_back(8'($urandom));
        repeat (32) body.push_back(8'($urandom));
        n = $urandom_range(0, 3);
        body.push_back(8'(n)); repeat (n) body.push_back(8'($urandom));
        n = 2 * $urandom_range(0, 3);
        body.push_back(8'h00); body.push_back(8'(n));
        repeat (n) body.push_back(8'($urandom));
        n = $urandom_range(0, 2);
        body.push_back(8'(n)); repeat (n) body.push_back(8'($urandom));
        if (exts.size() > 0 || $urandom_range(0, 1)) begin
            body.push_back(8'(exts.size() >> 8)); body.push_back(8'(exts.size() & 255));
            foreach (exts[k]) body.push_back(exts[k]);
        end
        pkt = {HS_CONTENT_TYPE, 8'h03, 8'h01,
               8'((body.size() + 4) >> 8), 8'((body.size() + 4) & 255),
               HS_CLIENT_HELLO, 8'h00, 8'((body.size()) >> 8), 8'(body.size() & 255)};
        foreach (body[k]) pkt.push_back(body[k]);
    endfunction

    // output side: per-transaction stall count, compare against oldest prediction
    initial begin
        t_result want;
        int      hold;
        i_stall = 1'b1;
        hold = $urandom_range(0, 3);
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            i_stall <= (hold > 0) && !feeding_done;
            @(posedge i_clk);
            if (i_stall) begin
                if (hold > 0) hold--;
            end else if (o_valid) begin
                hold = $urandom_range(0, 3);
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected transaction", o_is_verdict, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_is_verdict !== want.is_verdict)
                        report_mismatch("is_verdict", o_is_verdict, want.is_verdict);
                    if (o_name_byte !== want.name_byte)
                        report_mismatch("name_byte", o_name_byte, want.name_byte);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_has_name !== want.has_name)
                        report_mismatch("has_name", o_has_name, want.has_name);
                    if (o_name_length !== want.name_length)
                        report_mismatch("name_length", o_name_length, want.name_length);
                    if (o_record_length !== want.rec_len)
                        report_mismatch("rec_len", o_record_length, want.rec_len);
                    if (o_hello_version !== want.hello_version)
                        report_mismatch("hello_version", o_hello_version, want.hello_version);
                    if (o_last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", o_last_of_run, want.last_of_run);
                end
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        t_row         rows[$];
        t_row         row;
        byte unsigned pkt[$];
        int           sent, cut, kind, depth;
        mismatches = 0;
        feeding_done = 0;
        sent = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_end_of_buffer = 1'b0;
        parse_clear();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: short header, refusals, zero length, trailing bytes
        rows = '{
            '{8'h00, 1'b1, 1'b1, '{1'b1, 8'd0, ST_NEED, 1'b0, 8'd0, 16'd0, 16'd0, 1'b1}},
            '{8'h17, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b1, '{1'b1, 8'd0, ST_NOTCH, 1'b0, 8'd0, 16'd0, 16'd0, 1'b1}},
            '{8'h16, 1'b0, 1'b0, '0}, '{8'h03, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b1, 1'b1, '{1'b1, 8'd0, ST_MAL, 1'b0, 8'd0, 16'd0, 16'd0, 1'b1}},
            '{8'h16, 1'b0, 1'b0, '0}, '{8'h03, 1'b0, 1'b0, '0}, '{8'h03, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b1, '{1'b1, 8'd0, ST_NEED, 1'b0, 8'd0, 16'hFFFF, 16'd0, 1'b1}},
            '{8'h16, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'hAA, 1'b1, 1'b1, '{1'b1, 8'd0, ST_MAL, 1'b0, 8'd0, 16'd1, 16'd0, 1'b1}}
        };
        foreach (rows[k]) begin
            row = rows[k];
            if (row.known) begin
                send_byte(row.data, row.last);
                void'(pending_results.pop_back());
                pending_results.push_back(row.res);
            end else send_byte(row.data, row.last);
            sent++;
        end
        // host names of length one, the longest accepted and one over the limit; one record gets a trailing byte
        build_hello(pkt, 1, 1, 1);
        send_buffer(pkt);
        sent += pkt.size();
        build_hello(pkt, HOST_LIMIT - 1, 0, 0);
        pkt.push_back(8'hFF);
        send_buffer(pkt);
        sent += pkt.size();
        build_hello(pkt, HOST_LIMIT, 0, 0);
        send_buffer(pkt);
        sent += pkt.size();

        // hold off until every result has drained
        drain_results();

        while (sent < 850) begin
            kind = $urandom_range(0, 9);
            build_hello(pkt, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12),
                        $urandom_range(0, 1), $urandom_range(0, 1));
            if (kind == 0) begin
                cut = $urandom_range(1, pkt.size() - 1);
                while (pkt.size() > cut) void'(pkt.pop_back());
            end else if (kind == 1) begin
                depth = $urandom_range(0, pkt.size() - 1);
                pkt[depth] = 8'($urandom);
            end else if (kind == 2) begin
                pkt = {};
                repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
            end else if (kind == 3) begin
                repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
            end
            send_buffer(pkt);
            sent += pkt.size();
        end

        drain_results();
        feeding_done = 1;
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/tcse_pkg.sv
rtl/tcse_parser.sv
rtl/tcse_out_q.sv
rtl/tls_clienthello_sni_extractor_unit.sv
bench/tls_clienthello_sni_extractor_unit_tb.sv
